FILE: src/ecpr_pkg.sv
// ecpr_pkg: shared types and constants for the enhanced clock page replacement core
// beat structs for the access and result channels, outcome codes, default sizes
// no dependencies
package ecpr_pkg;

  localparam int FRAMES_DEF = 4;
  localparam int TAG_W      = 20;
  localparam int CNT_W      = 16;
  localparam int IDX_OUT_W  = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_FAULT = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [TAG_W-1:0] page_number;
    logic             write_access;
  } in_beat_t;

  typedef struct packed {
    outcome_t             outcome;
    logic [IDX_OUT_W-1:0] frame_index;
    logic [CNT_W-1:0]     fault_total;
  } out_beat_t;

endpackage

FILE: src/ecpr_victim_sel.sv
// ecpr_victim_sel: enhanced clock victim choice over the accessed and modified bits
// combinational priority scan from frame 0, gives the victim and the scanned A bits
// depends on ecpr_pkg (only FRAMES_DEF, as the default for FRAMES)
module ecpr_victim_sel #(
  parameter int FRAMES = ecpr_pkg::FRAMES_DEF,
  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic [FRAMES-1:0] acc,
  input  logic [FRAMES-1:0] mod,
  output logic [IDX_W-1:0]  victim,
  output logic [FRAMES-1:0] acc_after
);

  logic              found_clean;
  logic              found_dirty;
  logic              found_nomod;
  logic [IDX_W-1:0]  idx_clean;
  logic [IDX_W-1:0]  idx_dirty;
  logic [IDX_W-1:0]  idx_nomod;
  logic [FRAMES-1:0] passed;

  always_comb begin
    found_clean = 1'b0;
    found_dirty = 1'b0;
    found_nomod = 1'b0;
    idx_clean   = '0;
    idx_dirty   = '0;
    idx_nomod   = '0;
    passed      = '0;
    for (int i = 0; i < FRAMES; i++) begin
      // frames walked over before the first dirty, not-accessed one
      passed[i] = !found_dirty && !(mod[i] && !acc[i]);
      if (!found_clean && !acc[i] && !mod[i]) begin
        found_clean = 1'b1;
        idx_clean   = IDX_W'(i);
      end
      if (!found_dirty && mod[i] && !acc[i]) begin
        found_dirty = 1'b1;
        idx_dirty   = IDX_W'(i);
      end
      if (!found_nomod && !mod[i]) begin
        found_nomod = 1'b1;
        idx_nomod   = IDX_W'(i);
      end
    end

    if (found_clean) begin
      victim    = idx_clean;
      acc_after = acc;
    end else if (found_dirty) begin
      victim    = idx_dirty;
      acc_after = acc & ~passed;
    end else begin
      // full walk cleared every A bit, second pass takes lowest clean frame or frame 0
      victim    = found_nomod ? idx_nomod : '0;
      acc_after = '0;
    end
  end

endmodule

FILE: src/ecpr_frame_store.sv
// ecpr_frame_store: frame tags with valid, accessed and modified bits
// parallel tag compare, free frame search and state update for one access per cycle while fire is high
// depends on ecpr_pkg and ecpr_victim_sel
module ecpr_frame_store #(
  parameter int FRAMES = ecpr_pkg::FRAMES_DEF,
  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  logic [ecpr_pkg::TAG_W-1:0] page,
  input  logic                      wr,
  output ecpr_pkg::outcome_t        outcome,
  output logic [IDX_W-1:0]          frame
);

  logic [ecpr_pkg::TAG_W-1:0] tags_r [FRAMES];
  logic [FRAMES-1:0] valid_r, valid_nxt;
  logic [FRAMES-1:0] acc_r, acc_nxt;
  logic [FRAMES-1:0] mod_r, mod_nxt;

  logic             hit;
  logic             has_free;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] victim;
  logic [FRAMES-1:0] acc_scanned;
  logic             load;

  ecpr_victim_sel #(
    .FRAMES (FRAMES)
  ) u_victim_sel (
    .acc       (acc_r),
    .mod       (mod_r),
    .victim    (victim),
    .acc_after (acc_scanned)
  );

  always_comb begin
    hit      = 1'b0;
    has_free = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (!hit && valid_r[i] && tags_r[i] == page) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!has_free && !valid_r[i]) begin
        has_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    acc_nxt   = acc_r;
    mod_nxt   = mod_r;
    load      = 1'b0;
    if (hit) begin
      outcome          = ecpr_pkg::OUT_HIT;
      frame            = hit_idx;
      acc_nxt[hit_idx] = 1'b1;
      mod_nxt[hit_idx] = mod_r[hit_idx] | wr;
    end else if (has_free) begin
      outcome = ecpr_pkg::OUT_FILL;
      frame   = free_idx;
      load    = 1'b1;
    end else begin
      outcome = ecpr_pkg::OUT_FAULT;
      frame   = victim;
      acc_nxt = acc_scanned;
      load    = 1'b1;
    end
    if (load) begin
      valid_nxt[frame] = 1'b1;
      acc_nxt[frame]   = 1'b1;
      mod_nxt[frame]   = wr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      acc_r   <= '0;
      mod_r   <= '0;
    end else if (fire) begin
      valid_r <= valid_nxt;
      acc_r   <= acc_nxt;
      mod_r   <= mod_nxt;
    end
  end

  // tags are only compared while valid, so they need no reset
  always_ff @(posedge clk) begin
    if (fire && load) begin
      tags_r[frame] <= page;
    end
  end

endmodule

FILE: src/enhanced_clock_page_replacement_core.sv
// enhanced_clock_page_replacement_core: top level of the page replacement block
// input register, frame store with victim scan, fault counter and result register
// depends on ecpr_pkg, ecpr_frame_store, ecpr_victim_sel
//
// Usage:
//   in_valid/in_stall/in_data carry one page access per beat: page number and
//   write flag. out_valid/out_stall/out_data return one result per access:
//   outcome (hit, fill of a free frame, fault with replacement), the frame
//   that now holds the page, and the saturating fault count including this
//   access.
//   Throughput is one access per cycle while out_stall is low: the tag
//   compare, free frame search and enhanced clock victim scan over all
//   frames sit in one combinational stage between the input register and
//   the result register, and the frame state is updated at the same edge
//   the result is registered, so the next access always sees it.
//   Reset (rst_n low, synchronous) empties every frame, clears the accessed
//   and modified bits and the fault count; no items are held after it.
//   When out_stall is high with a result waiting, the result register holds
//   and the input register can still take one more beat; after that
//   in_stall rises until the receiver takes the waiting result.
module enhanced_clock_page_replacement_core #(
  parameter int FRAMES = ecpr_pkg::FRAMES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ecpr_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ecpr_pkg::out_beat_t out_data
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  logic                          s1_vld_r, s1_vld_nxt;
  ecpr_pkg::in_beat_t            s1_beat_r;
  logic                          out_vld_r, out_vld_nxt;
  ecpr_pkg::out_beat_t           out_beat_r;
  logic [ecpr_pkg::CNT_W-1:0]    fault_cnt_r, fault_cnt_nxt;

  logic                          adv;
  logic                          accept;
  ecpr_pkg::outcome_t            outcome;
  logic [IDX_W-1:0]              frame;

  ecpr_frame_store #(
    .FRAMES (FRAMES)
  ) u_frame_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (adv),
    .page    (s1_beat_r.page_number),
    .wr      (s1_beat_r.write_access),
    .outcome (outcome),
    .frame   (frame)
  );

  assign adv      = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    fault_cnt_nxt = fault_cnt_r;
    if (outcome == ecpr_pkg::OUT_FAULT && fault_cnt_r != ecpr_pkg::CNT_MAX) begin
      fault_cnt_nxt = fault_cnt_r + 1'b1;
    end
    s1_vld_nxt = accept ? 1'b1 : (adv ? 1'b0 : s1_vld_r);
    out_vld_nxt = adv ? 1'b1 : (out_vld_r && !out_stall ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      fault_cnt_r <= '0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        fault_cnt_r <= fault_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_beat_r <= in_data;
    end
    if (adv) begin
      out_beat_r.outcome     <= outcome;
      out_beat_r.frame_index <= ecpr_pkg::IDX_OUT_W'(frame);
      out_beat_r.fault_total <= fault_cnt_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_beat_r;

endmodule

FILE: dv/ecpr_replacement_checker.sv
`timescale 1ns / 1ps
// ecpr_replacement_checker: watches the access and result channels of the page replacement core
// keeps its own frame model, predicts each result and compares it field by field
// depends on ecpr_pkg
module ecpr_replacement_checker #(
  parameter int FRAMES = ecpr_pkg::FRAMES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  ecpr_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  ecpr_pkg::out_beat_t out_data,
  output int unsigned         open_count,
  output int unsigned         fail_count
);

  logic [ecpr_pkg::TAG_W-1:0] page_tag [FRAMES];
  logic [FRAMES-1:0]          frame_live;
  logic [FRAMES-1:0]          ref_bit;
  logic [FRAMES-1:0]          dirty_bit;
  logic [ecpr_pkg::CNT_W-1:0] fault_cnt;
  ecpr_pkg::out_beat_t        results_due [$];
  int unsigned                mismatches = 0;

  function automatic void log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  // enhanced clock scan, always from frame 0; clears ref bits it walks past
  function automatic int unsigned choose_victim();
    int unsigned victim;
    bit          found;
    victim = 0;
    found  = 1'b0;
    for (int pass = 0; pass < 2 && !found; pass++) begin
      for (int i = 0; i < FRAMES && !found; i++) begin
        if (!ref_bit[i] && !dirty_bit[i]) begin
          victim = i;
          found  = 1'b1;
        end
      end
      for (int i = 0; i < FRAMES && !found; i++) begin
        if (dirty_bit[i] && !ref_bit[i]) begin
          victim = i;
          found  = 1'b1;
        end else begin
          ref_bit[i] = 1'b0;
        end
      end
    end
    return victim;
  endfunction

  function automatic ecpr_pkg::out_beat_t predict_access(ecpr_pkg::in_beat_t acc_in);
    ecpr_pkg::out_beat_t res;
    int unsigned         slot;
    int unsigned         free_slot;
    bit                  hit;
    bit                  has_free;
    slot      = 0;
    free_slot = 0;
    hit       = 1'b0;
    has_free  = 1'b0;
    for (int i = 0; i < FRAMES; i++) begin
      if (frame_live[i] && page_tag[i] == acc_in.page_number && !hit) begin
        hit  = 1'b1;
        slot = i;
      end
      if (!frame_live[i] && !has_free) begin
        has_free  = 1'b1;
        free_slot = i;
      end
    end
    if (hit) begin
      res.outcome     = ecpr_pkg::OUT_HIT;
      ref_bit[slot]   = 1'b1;
      dirty_bit[slot] = dirty_bit[slot] | acc_in.write_access;
    end else begin
      if (has_free) begin
        res.outcome = ecpr_pkg::OUT_FILL;
        slot        = free_slot;
      end else begin
        res.outcome = ecpr_pkg::OUT_FAULT;
        if (fault_cnt != ecpr_pkg::CNT_MAX) fault_cnt++;
        slot = choose_victim();
      end
      page_tag[slot]   = acc_in.page_number;
      frame_live[slot] = 1'b1;
      ref_bit[slot]    = 1'b1;
      dirty_bit[slot]  = acc_in.write_access;
    end
    res.frame_index = slot[ecpr_pkg::IDX_OUT_W-1:0];
    res.fault_total = fault_cnt;
    return res;
  endfunction

  always @(posedge clk) begin
    ecpr_pkg::out_beat_t want;
    if (!rst_n) begin
      frame_live = '0;
      ref_bit    = '0;
      dirty_bit  = '0;
      fault_cnt  = '0;
      results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          log_mismatch($sformatf("result beat with nothing due: outcome %0d frame %0d faults %0d",
                                 out_data.outcome, out_data.frame_index, out_data.fault_total));
        end else begin
          want = results_due.pop_front();
          if (out_data.outcome !== want.outcome)
            log_mismatch($sformatf("outcome: expected %0d, got %0d",
                                   want.outcome, out_data.outcome));
          if (out_data.frame_index !== want.frame_index)
            log_mismatch($sformatf("frame_index: expected %0d, got %0d",
                                   want.frame_index, out_data.frame_index));
          if (out_data.fault_total !== want.fault_total)
            log_mismatch($sformatf("fault_total: expected %0d, got %0d",
                                   want.fault_total, out_data.fault_total));
        end
      end
      if (in_valid && !in_stall) results_due.push_back(predict_access(in_data));
    end
    open_count <= results_due.size();
    fail_count <= mismatches;
  end

endmodule

FILE: dv/enhanced_clock_page_replacement_core_tb.sv
`timescale 1ns / 1ps
// enhanced_clock_page_replacement_core_tb: stimulus and verdict for the page replacement core
// depends on ecpr_pkg, enhanced_clock_page_replacement_core and ecpr_replacement_checker
module enhanced_clock_page_replacement_core_tb;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned RANDOM_ACCESSES = 1850;
  localparam int unsigned MISS_ACCESSES   = 40;
  localparam int unsigned TAIL_ACCESSES   = 40;
  localparam int unsigned DRAIN_CYCLES    = 20;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  ecpr_pkg::in_beat_t         in_data   = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  ecpr_pkg::out_beat_t        out_data;
  logic                       quiet     = 1'b0;
  int unsigned                open_count;
  int unsigned                fail_count;
  int unsigned                cycles    = 0;
  logic [ecpr_pkg::TAG_W-1:0] hot_pages [8];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  enhanced_clock_page_replacement_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ecpr_replacement_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .open_count (open_count),
    .fail_count (fail_count)
  );

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 20);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // valid stays high from one beat to the next unless a gap is drawn
  task automatic send_access(input logic [ecpr_pkg::TAG_W-1:0] page, input logic wr);
    int unsigned gap;
    gap = 0;
    if (!quiet) while ($urandom_range(0, 99) < 20) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{page_number: page, write_access: wr};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
  endtask

  // mostly a small working set so hits and every victim class show up
  function automatic logic [ecpr_pkg::TAG_W-1:0] pick_page(int unsigned span);
    if ($urandom_range(0, 99) < 12) return ecpr_pkg::TAG_W'($urandom);
    return hot_pages[$urandom_range(0, span - 1)];
  endfunction

  initial begin
    ecpr_pkg::in_beat_t opening [20];
    int unsigned        span;
    int unsigned        wr_pct;
    opening = '{
      '{20'h00000, 1'b0}, '{20'hFFFFF, 1'b1}, '{20'h55555, 1'b0}, '{20'hAAAAA, 1'b1},
      '{20'hFFFFF, 1'b0}, '{20'h00000, 1'b1},
      // full set, all ref bits set: clearing walk then clean frame
      '{20'h12345, 1'b0},
      // dirty frame with ref clear taken first
      '{20'h54321, 1'b1}, '{20'h11111, 1'b0}, '{20'h22222, 1'b0}, '{20'h33333, 1'b0},
      // clean unreferenced frame found without a walk
      '{20'h44444, 1'b1},
      '{20'h11111, 1'b1}, '{20'h12345, 1'b1}, '{20'h33333, 1'b1}, '{20'h44444, 1'b1},
      // every frame dirty and referenced: falls back to frame 0, then dirty frames with ref clear are taken
      '{20'hFFFFE, 1'b0}, '{20'hFFFFE, 1'b1}, '{20'h00001, 1'b1}, '{20'h00000, 1'b0}
    };
    span   = 4;
    wr_pct = 50;
    foreach (hot_pages[k]) hot_pages[k] = ecpr_pkg::TAG_W'($urandom);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening[k]) send_access(opening[k].page_number, opening[k].write_access);
    wait_all_results();

    for (int n = 0; n < RANDOM_ACCESSES; n++) begin
      if (n % 100 == 0) begin
        span   = $urandom_range(3, 8);
        wr_pct = $urandom_range(0, 100);
        foreach (hot_pages[k]) hot_pages[k] = ecpr_pkg::TAG_W'($urandom);
      end
      if (n == 900) quiet <= 1'b1;
      if (n == 1200) quiet <= 1'b0;
      send_access(pick_page(span), $urandom_range(0, 99) < wr_pct);
    end
    wait_all_results();

    // distinct pages, every access misses: a long run of faults
    for (int unsigned n = 0; n < MISS_ACCESSES; n++)
      send_access(ecpr_pkg::TAG_W'(20'h80000 | n), $urandom_range(0, 1));

    for (int n = 0; n < TAIL_ACCESSES; n++)
      send_access(pick_page(4), $urandom_range(0, 1));

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ecpr_pkg.sv
src/ecpr_victim_sel.sv
src/ecpr_frame_store.sv
src/enhanced_clock_page_replacement_core.sv
dv/ecpr_replacement_checker.sv
dv/enhanced_clock_page_replacement_core_tb.sv
